// File: rtl/core/srpc_pkg.sv
// shared types, widths, command codes and helper functions of the slide rail point constraint
`default_nettype none

package srpc_pkg;

	// coordinate and internal widths
	localparam int CW    = 32;            // coordinate width
	localparam int DW    = CW + 1;        // difference and magnitude width
	localparam int LW    = CW + 1;        // rail length width
	localparam int SQW   = 2 * CW + 2;    // squared length, dot product and product width
	localparam int BLO   = 17;            // low half of the multiplier operand
	localparam int BHI   = LW - BLO;      // high half of the multiplier operand
	localparam int QW    = LW + 2;        // quotient width
	localparam int DVW   = LW + QW - 1;   // shifted divisor width
	localparam int OFFW  = QW + 2;        // unsaturated offset width
	localparam int CNTW  = 6;             // iteration counter width
	localparam int MRGW  = 31;            // detach margin width
	localparam int TOLW  = 16;            // zero tolerance width
	localparam int SQ_STEPS  = LW;        // square root iterations
	localparam int DIV_STEPS = QW;        // divider iterations

	typedef logic signed [CW-1:0]   coord_t;
	typedef logic signed [DW-1:0]   diff_t;
	typedef logic        [DW-1:0]   mag_t;
	typedef logic signed [OFFW-1:0] off_t;

	// event codes
	localparam logic [1:0] FN_TICK  = 2'd0;
	localparam logic [1:0] FN_BEGIN = 2'd1;
	localparam logic [1:0] FN_CLEAR = 2'd2;

	// register indexes
	localparam logic [1:0] REG_DETACH_ALLOWED = 2'd0;
	localparam logic [1:0] REG_DETACH_MARGIN  = 2'd1;
	localparam logic [1:0] REG_ZERO_TOLERANCE = 2'd2;

	// datapath operations
	localparam logic [3:0] OP_NOP       = 4'd0;
	localparam logic [3:0] OP_LOAD      = 4'd1;
	localparam logic [3:0] OP_MUL_LO    = 4'd2;
	localparam logic [3:0] OP_MUL_HI    = 4'd3;
	localparam logic [3:0] OP_ACC       = 4'd4;
	localparam logic [3:0] OP_SQRT_INIT = 4'd5;
	localparam logic [3:0] OP_SQRT_STEP = 4'd6;
	localparam logic [3:0] OP_DIV_INIT  = 4'd7;
	localparam logic [3:0] OP_DIV_STEP  = 4'd8;
	localparam logic [3:0] OP_CLAMP     = 4'd9;
	localparam logic [3:0] OP_PROJ      = 4'd10;
	localparam logic [3:0] OP_WRITE     = 4'd11;

	// multiplier operand pairs
	localparam logic [1:0] SEL_VV = 2'd0;   // |v| * |v|
	localparam logic [1:0] SEL_VW = 2'd1;   // |v| * |w|
	localparam logic [1:0] SEL_VC = 2'd2;   // |v| * clamped distance

	// result kinds
	localparam logic [2:0] KIND_ZERO   = 3'd0;
	localparam logic [2:0] KIND_BEGIN  = 3'd1;
	localparam logic [2:0] KIND_CLEAR  = 3'd2;
	localparam logic [2:0] KIND_DELTA  = 3'd3;
	localparam logic [2:0] KIND_DETACH = 3'd4;
	localparam logic [2:0] KIND_PROJ   = 3'd5;

	typedef struct packed {
		logic [3:0] op;
		logic [1:0] sel;
		logic [1:0] axis;
		logic [2:0] kind;
	} cmd_t;

	typedef struct packed {
		logic [1:0] func;
		logic       delta_big;
		logic       len_small;
		logic       detach;
	} sts_t;

	// magnitude of a coordinate difference
	function automatic mag_t mag_d(input diff_t x);
		mag_t r;
		r = x[DW-1] ? mag_t'(-x) : mag_t'(x);
		return r;
	endfunction

	// magnitude of an unsaturated offset
	function automatic logic [OFFW-1:0] mag_o(input off_t x);
		logic [OFFW-1:0] r;
		r = x[OFFW-1] ? OFFW'(-x) : OFFW'(x);
		return r;
	endfunction

	// saturate to the coordinate range
	function automatic coord_t sat_c(input off_t x);
		off_t   hi;
		off_t   lo;
		coord_t r;
		hi = off_t'({1'b0, {(CW-1){1'b1}}});
		lo = -hi - off_t'(1);
		if (x > hi) begin
			r = coord_t'(hi);
		end else if (x < lo) begin
			r = coord_t'(lo);
		end else begin
			r = coord_t'(x);
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// File: rtl/core/srpc_datapath.sv
// datapath: operand registers, shared multiplier, square root and divider, output word
`default_nettype none

module srpc_datapath (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire srpc_pkg::cmd_t               cmd,
	output      srpc_pkg::sts_t               sts,
	input  wire logic                         cfg_we,
	input  wire logic [1:0]                   cfg_index,
	input  wire logic [srpc_pkg::MRGW-1:0]    cfg_data,
	input  wire logic [1:0]                   func,
	input  wire srpc_pkg::coord_t             rail_start_x,
	input  wire srpc_pkg::coord_t             rail_start_y,
	input  wire srpc_pkg::coord_t             rail_start_z,
	input  wire srpc_pkg::coord_t             rail_end_x,
	input  wire srpc_pkg::coord_t             rail_end_y,
	input  wire srpc_pkg::coord_t             rail_end_z,
	input  wire srpc_pkg::coord_t             snap_x,
	input  wire srpc_pkg::coord_t             snap_y,
	input  wire srpc_pkg::coord_t             snap_z,
	output      srpc_pkg::coord_t             offset_x,
	output      srpc_pkg::coord_t             offset_y,
	output      srpc_pkg::coord_t             offset_z,
	output      logic                         apply_offset,
	output      logic                         rail_moved,
	output      logic                         detached
);
	import srpc_pkg::*;

	// configuration registers
	logic              allow_q;
	logic [MRGW-1:0]   margin_q;
	logic [TOLW-1:0]   tol_q;

	// item registers
	logic [1:0] func_q;
	coord_t     s_q [3];
	coord_t     e_q [3];
	coord_t     p_q [3];
	coord_t     last_q [3];

	// arithmetic registers
	logic [SQW-1:0] prod_q;
	logic [SQW-1:0] l2_q;
	logic [SQW-1:0] pos_q;
	logic [SQW-1:0] neg_q;
	logic [SQW-1:0] sq_op_q;
	logic [SQW-1:0] sq_res_q;
	logic [SQW-1:0] sq_one_q;
	logic [SQW-1:0] rem_q;
	logic [DVW-1:0] dvs_q;
	logic [QW-1:0]  quo_q;
	logic           dneg_q;
	logic           det_q;
	logic [LW-1:0]  c_q;
	off_t           off_q [3];

	// output word
	coord_t out_off_q [3];
	logic   apply_q;
	logic   rail_q;
	logic   det_out_q;

	// combinational values
	diff_t          v [3];
	diff_t          w [3];
	diff_t          dl [3];
	mag_t           mv [3];
	mag_t           mw [3];
	logic [2:0]     negp;
	logic [2:0]     big;
	logic [2:0]     pbig;
	mag_t           op_a;
	logic [LW-1:0]  op_b;
	logic [DW+BLO-1:0] mlo;
	logic [DW+BHI-1:0] mhi;
	logic [SQW-1:0] sq_t;
	logic           sq_ge;
	logic           dv_ge;
	logic [LW-1:0]  len;
	logic [LW:0]    len_mrg;
	off_t           qsv;

	// differences and magnitudes per axis
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			v[i]    = DW'(e_q[i]) - DW'(s_q[i]);
			w[i]    = DW'(p_q[i]) - DW'(s_q[i]);
			dl[i]   = DW'(s_q[i]) - DW'(last_q[i]);
			mv[i]   = mag_d(v[i]);
			mw[i]   = mag_d(w[i]);
			negp[i] = v[i][DW-1] ^ w[i][DW-1];
			big[i]  = mag_d(dl[i]) > DW'(tol_q);
			pbig[i] = mag_o(off_q[i]) > OFFW'(tol_q);
		end
	end

	// multiplier operand select
	always_comb begin
		op_a = mv[cmd.axis];
		case (cmd.sel)
			SEL_VV:  op_b = mv[cmd.axis];
			SEL_VW:  op_b = mw[cmd.axis];
			default: op_b = c_q;
		endcase
	end

	// half-width partial products
	assign mlo = op_a * op_b[BLO-1:0];
	assign mhi = op_a * op_b[LW-1:BLO];

	// square root and divider steps
	assign sq_t    = sq_res_q + sq_one_q;
	assign sq_ge   = sq_op_q >= sq_t;
	assign dv_ge   = DVW'(rem_q) >= dvs_q;
	assign len     = sq_res_q[LW-1:0];
	assign len_mrg = (LW+1)'(len) + (LW+1)'(margin_q);
	assign qsv     = off_t'(quo_q);

	// status to the controller
	assign sts.func      = func_q;
	assign sts.delta_big = |big;
	assign sts.len_small = len <= LW'(tol_q);
	assign sts.detach    = det_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			allow_q  <= 1'b0;
			margin_q <= '0;
			tol_q    <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_DETACH_ALLOWED: allow_q  <= cfg_data[0];
				REG_DETACH_MARGIN:  margin_q <= cfg_data;
				REG_ZERO_TOLERANCE: tol_q    <= cfg_data[TOLW-1:0];
				default: ;
			endcase
		end
	end

	// rail start snapshot, cleared so a stale value never shows
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) last_q[i] <= '0;
		end else if (cmd.op == OP_WRITE && (cmd.kind == KIND_BEGIN ||
				cmd.kind == KIND_DELTA || cmd.kind == KIND_PROJ)) begin
			for (int i = 0; i < 3; i++) last_q[i] <= s_q[i];
		end
	end

	// operation sequencing
	always_ff @(posedge clk) begin
		unique case (cmd.op)
			OP_LOAD: begin
				func_q <= func;
				s_q[0] <= rail_start_x;
				s_q[1] <= rail_start_y;
				s_q[2] <= rail_start_z;
				e_q[0] <= rail_end_x;
				e_q[1] <= rail_end_y;
				e_q[2] <= rail_end_z;
				p_q[0] <= snap_x;
				p_q[1] <= snap_y;
				p_q[2] <= snap_z;
				l2_q   <= '0;
				pos_q  <= '0;
				neg_q  <= '0;
			end
			OP_MUL_LO: prod_q <= SQW'(mlo);
			OP_MUL_HI: prod_q <= prod_q + (SQW'(mhi) << BLO);
			OP_ACC: begin
				case (cmd.sel)
					SEL_VV: l2_q <= l2_q + prod_q;
					SEL_VW: begin
						if (negp[cmd.axis]) begin
							neg_q <= neg_q + prod_q;
						end else begin
							pos_q <= pos_q + prod_q;
						end
					end
					default: ;
				endcase
			end
			OP_SQRT_INIT: begin
				sq_op_q  <= l2_q;
				sq_res_q <= '0;
				sq_one_q <= SQW'(1) << (SQW - 2);
			end
			OP_SQRT_STEP: begin
				if (sq_ge) begin
					sq_op_q  <= sq_op_q - sq_t;
					sq_res_q <= (sq_res_q >> 1) + sq_one_q;
				end else begin
					sq_res_q <= sq_res_q >> 1;
				end
				sq_one_q <= sq_one_q >> 2;
			end
			OP_DIV_INIT: begin
				if (cmd.sel == SEL_VC) begin
					rem_q <= prod_q;
				end else begin
					dneg_q <= pos_q < neg_q;
					rem_q  <= (pos_q < neg_q) ? neg_q - pos_q : pos_q - neg_q;
				end
				dvs_q <= DVW'(len) << (QW - 1);
				quo_q <= '0;
			end
			OP_DIV_STEP: begin
				if (dv_ge) begin
					rem_q <= rem_q - dvs_q[SQW-1:0];
				end
				quo_q <= {quo_q[QW-2:0], dv_ge};
				dvs_q <= dvs_q >> 1;
			end
			OP_CLAMP: begin
				det_q <= allow_q && (dneg_q ? quo_q > QW'(margin_q)
				                            : quo_q > QW'(len_mrg));
				if (dneg_q) begin
					c_q <= '0;
				end else if (quo_q > QW'(len)) begin
					c_q <= len;
				end else begin
					c_q <= quo_q[LW-1:0];
				end
			end
			OP_PROJ: begin
				off_q[cmd.axis] <= (v[cmd.axis][DW-1] ? -qsv : qsv) - OFFW'(w[cmd.axis]);
			end
			OP_WRITE: begin
				for (int i = 0; i < 3; i++) out_off_q[i] <= '0;
				apply_q   <= 1'b0;
				rail_q    <= 1'b0;
				det_out_q <= 1'b0;
				case (cmd.kind)
					KIND_DELTA: begin
						for (int i = 0; i < 3; i++) out_off_q[i] <= sat_c(OFFW'(dl[i]));
						apply_q <= 1'b1;
						rail_q  <= 1'b1;
					end
					KIND_PROJ: begin
						for (int i = 0; i < 3; i++) out_off_q[i] <= sat_c(off_q[i]);
						apply_q <= |pbig;
					end
					KIND_DETACH: det_out_q <= 1'b1;
					default: ;
				endcase
			end
			default: ;
		endcase
	end

	assign offset_x     = out_off_q[0];
	assign offset_y     = out_off_q[1];
	assign offset_z     = out_off_q[2];
	assign apply_offset = apply_q;
	assign rail_moved   = rail_q;
	assign detached     = det_out_q;

endmodule

`default_nettype wire

// File: rtl/core/srpc_ctrl.sv
// controller: slide state, operation sequencer and handshakes
`default_nettype none

module srpc_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	output      logic           in_stall,
	output      logic           out_valid,
	input  wire logic           out_stall,
	input  wire srpc_pkg::sts_t sts,
	output      srpc_pkg::cmd_t cmd
);
	import srpc_pkg::*;

	localparam logic [3:0] S_IDLE     = 4'd0;
	localparam logic [3:0] S_DECODE   = 4'd1;
	localparam logic [3:0] S_MUL_LO   = 4'd2;
	localparam logic [3:0] S_MUL_HI   = 4'd3;
	localparam logic [3:0] S_ACC      = 4'd4;
	localparam logic [3:0] S_SQ_INIT  = 4'd5;
	localparam logic [3:0] S_SQ_STEP  = 4'd6;
	localparam logic [3:0] S_SHORT    = 4'd7;
	localparam logic [3:0] S_DIV_INIT = 4'd8;
	localparam logic [3:0] S_DIV_STEP = 4'd9;
	localparam logic [3:0] S_CLAMP    = 4'd10;
	localparam logic [3:0] S_CHECK    = 4'd11;
	localparam logic [3:0] S_PROJ     = 4'd12;
	localparam logic [3:0] S_FINISH   = 4'd13;

	logic [3:0]      state_q;
	logic [1:0]      axis_q;
	logic [1:0]      sel_q;
	logic [2:0]      kind_q;
	logic [CNTW-1:0] cnt_q;
	logic            active_q;
	logic            have_last_q;
	logic            out_valid_q;
	logic            write_ok;

	assign in_stall  = state_q != S_IDLE;
	assign out_valid = out_valid_q;
	assign write_ok  = !out_valid_q || !out_stall;

	// command decode
	always_comb begin
		cmd.sel  = sel_q;
		cmd.axis = axis_q;
		cmd.kind = kind_q;
		unique case (state_q)
			S_IDLE:     cmd.op = in_valid ? OP_LOAD : OP_NOP;
			S_MUL_LO:   cmd.op = OP_MUL_LO;
			S_MUL_HI:   cmd.op = OP_MUL_HI;
			S_ACC:      cmd.op = OP_ACC;
			S_SQ_INIT:  cmd.op = OP_SQRT_INIT;
			S_SQ_STEP:  cmd.op = OP_SQRT_STEP;
			S_DIV_INIT: cmd.op = OP_DIV_INIT;
			S_DIV_STEP: cmd.op = OP_DIV_STEP;
			S_CLAMP:    cmd.op = OP_CLAMP;
			S_PROJ:     cmd.op = OP_PROJ;
			S_FINISH:   cmd.op = write_ok ? OP_WRITE : OP_NOP;
			default:    cmd.op = OP_NOP;
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			axis_q      <= '0;
			sel_q       <= SEL_VV;
			kind_q      <= KIND_ZERO;
			cnt_q       <= '0;
			active_q    <= 1'b0;
			have_last_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_DECODE;
					end
				end
				S_DECODE: begin
					state_q <= S_FINISH;
					kind_q  <= KIND_ZERO;
					axis_q  <= '0;
					sel_q   <= SEL_VV;
					if (sts.func == FN_BEGIN) begin
						kind_q <= KIND_BEGIN;
					end else if (sts.func == FN_CLEAR) begin
						kind_q <= KIND_CLEAR;
					end else if (sts.func == FN_TICK && active_q) begin
						if (have_last_q && sts.delta_big) begin
							kind_q <= KIND_DELTA;
						end else begin
							state_q <= S_MUL_LO;
						end
					end
				end
				S_MUL_LO: state_q <= S_MUL_HI;
				S_MUL_HI: state_q <= S_ACC;
				S_ACC: begin
					case (sel_q)
						SEL_VV: begin
							sel_q   <= SEL_VW;
							state_q <= S_MUL_LO;
						end
						SEL_VW: begin
							if (axis_q == 2'd2) begin
								state_q <= S_SQ_INIT;
							end else begin
								axis_q  <= axis_q + 2'd1;
								sel_q   <= SEL_VV;
								state_q <= S_MUL_LO;
							end
						end
						default: state_q <= S_DIV_INIT;
					endcase
				end
				S_SQ_INIT: begin
					cnt_q   <= '0;
					state_q <= S_SQ_STEP;
				end
				S_SQ_STEP: begin
					cnt_q <= cnt_q + CNTW'(1);
					if (cnt_q == CNTW'(SQ_STEPS - 1)) begin
						state_q <= S_SHORT;
					end
				end
				S_SHORT: begin
					if (sts.len_small) begin
						kind_q  <= KIND_ZERO;
						state_q <= S_FINISH;
					end else begin
						state_q <= S_DIV_INIT;
					end
				end
				S_DIV_INIT: begin
					cnt_q   <= '0;
					state_q <= S_DIV_STEP;
				end
				S_DIV_STEP: begin
					cnt_q <= cnt_q + CNTW'(1);
					if (cnt_q == CNTW'(DIV_STEPS - 1)) begin
						state_q <= (sel_q == SEL_VC) ? S_PROJ : S_CLAMP;
					end
				end
				S_CLAMP: state_q <= S_CHECK;
				S_CHECK: begin
					if (sts.detach) begin
						kind_q  <= KIND_DETACH;
						state_q <= S_FINISH;
					end else begin
						axis_q  <= '0;
						sel_q   <= SEL_VC;
						state_q <= S_MUL_LO;
					end
				end
				S_PROJ: begin
					if (axis_q == 2'd2) begin
						kind_q  <= KIND_PROJ;
						state_q <= S_FINISH;
					end else begin
						axis_q  <= axis_q + 2'd1;
						state_q <= S_MUL_LO;
					end
				end
				S_FINISH: begin
					if (write_ok) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
						case (kind_q)
							KIND_BEGIN: begin
								active_q    <= 1'b1;
								have_last_q <= 1'b1;
							end
							KIND_CLEAR, KIND_DETACH: begin
								active_q    <= 1'b0;
								have_last_q <= 1'b0;
							end
							KIND_PROJ: have_last_q <= 1'b1;
							default: ;
						endcase
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire

// File: rtl/core/slide_rail_point_constraint_top.sv
// Begin, clear, idle ticks and rail moves go from input accept through decode to the finish
// state; a projecting tick runs nine two-step multiplies, a 33-step square root, then
// 35-step divides for the distance and for each of three axes on one shared divider.
// Throughput: one word at a time; the next word is taken once the sequencer is back in idle.
// Reset: arst_n clears slide state, stored rail start, configuration and output valid.
// top level: slide rail point constraint
`default_nettype none

module slide_rail_point_constraint_top (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      cfg_we,
	input  wire logic [1:0]                cfg_index,
	input  wire logic [srpc_pkg::MRGW-1:0] cfg_data,
	input  wire logic                      in_valid,
	output      logic                      in_stall,
	input  wire logic [1:0]                func,
	input  wire srpc_pkg::coord_t          rail_start_x,
	input  wire srpc_pkg::coord_t          rail_start_y,
	input  wire srpc_pkg::coord_t          rail_start_z,
	input  wire srpc_pkg::coord_t          rail_end_x,
	input  wire srpc_pkg::coord_t          rail_end_y,
	input  wire srpc_pkg::coord_t          rail_end_z,
	input  wire srpc_pkg::coord_t          snap_x,
	input  wire srpc_pkg::coord_t          snap_y,
	input  wire srpc_pkg::coord_t          snap_z,
	output      logic                      out_valid,
	input  wire logic                      out_stall,
	output      srpc_pkg::coord_t          offset_x,
	output      srpc_pkg::coord_t          offset_y,
	output      srpc_pkg::coord_t          offset_z,
	output      logic                      apply_offset,
	output      logic                      rail_moved,
	output      logic                      detached
);
	import srpc_pkg::*;

	cmd_t cmd;
	sts_t sts;

	// sequencer
	srpc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	// arithmetic and storage
	srpc_datapath u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.func         (func),
		.rail_start_x (rail_start_x),
		.rail_start_y (rail_start_y),
		.rail_start_z (rail_start_z),
		.rail_end_x   (rail_end_x),
		.rail_end_y   (rail_end_y),
		.rail_end_z   (rail_end_z),
		.snap_x       (snap_x),
		.snap_y       (snap_y),
		.snap_z       (snap_z),
		.offset_x     (offset_x),
		.offset_y     (offset_y),
		.offset_z     (offset_z),
		.apply_offset (apply_offset),
		.rail_moved   (rail_moved),
		.detached     (detached)
	);

`ifndef SYNTHESIS
	// a detached word carries no offset
	a_detach_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && detached) |-> (!apply_offset && !rail_moved &&
			offset_x == '0 && offset_y == '0 && offset_z == '0))
		else $error("detached word carries an offset");

	// a rail move is always applied
	a_move_applied: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && rail_moved) |-> (apply_offset && !detached))
		else $error("rail move without apply");

	// an accepted word blocks the input for the next cycle
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("input taken twice in a row");
`endif

endmodule

`default_nettype wire
